// ===== rtl/core/nbvm_pkg.sv =====
// Shared types and constants for the NaN-boxed register VM execute block.
`default_nettype none
package nbvm_pkg;

    localparam int NUM_REGS   = 256;
    localparam int POOL_DEPTH = 256;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  pool_index;
        logic [63:0] pool_value;
        logic [31:0] instr_word;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] return_value;
        logic        return_is_number;
    } t_rsp;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_HALT     = 3'd1;
    localparam logic [2:0] ST_RETURN   = 3'd2;
    localparam logic [2:0] ST_TYPE_ERR = 3'd3;
    localparam logic [2:0] ST_BAD_OP   = 3'd4;
    localparam logic [2:0] ST_POOL     = 3'd5;

    localparam logic [7:0] OP_HALT  = 8'd0;
    localparam logic [7:0] OP_LOADK = 8'd1;
    localparam logic [7:0] OP_ADD   = 8'd2;
    localparam logic [7:0] OP_RET   = 8'd3;
    localparam logic [7:0] OP_MOV   = 8'd4;

    localparam logic [63:0] BOX_MASK  = 64'h7ffc000000000000;
    localparam logic [63:0] CANON_NAN = 64'h7ff8000000000000;

    // Fields of a request that has been decoded and is waiting on register reads.
    typedef struct packed {
        logic        is_pool;
        logic [7:0]  op;
        logic [7:0]  a;
    } t_ctl;

    function automatic logic is_plain_num(input logic [63:0] v);
        return (v & BOX_MASK) != BOX_MASK;
    endfunction

    // Count of leading zeros of a 56-bit word.
    function automatic logic [5:0] lzc56(input logic [55:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd56;
        found = 1'b0;
        for (int i = 55; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 6'(55 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/nbvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nbvm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/nbvm_fadd.sv =====
// Two-stage IEEE double adder, round to nearest even, NaN results canonical.
`default_nettype none
module nbvm_fadd (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic      [63:0] o_sum
);
    import nbvm_pkg::*;

    // Stage one: classify, align and add the significands.
    logic        a_big;
    logic [63:0] x, y;
    logic [10:0] ex, ey, ediff;
    logic [52:0] mx, my;
    logic [55:0] ax, ay, ay_sh;
    logic        sticky;
    logic [56:0] sum;
    logic        xnan, ynan, xinf, yinf;
    logic        sub;

    logic        r_special;
    logic [63:0] r_special_val;
    logic        r_sign;
    logic [10:0] r_exp;
    logic [56:0] r_sum;
    logic        r_zero_sign;

    always_comb begin
        a_big = i_a[62:0] >= i_b[62:0];
        x = a_big ? i_a : i_b;
        y = a_big ? i_b : i_a;
        ex = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
        ey = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
        mx = {x[62:52] != 11'd0, x[51:0]};
        my = {y[62:52] != 11'd0, y[51:0]};
        ediff = ex - ey;
        ax = {mx, 3'b000};
        ay = {my, 3'b000};
        if (ediff >= 11'd56) begin
            ay_sh = 56'd0;
            sticky = |my;
        end else begin
            ay_sh = ay >> ediff[5:0];
            sticky = |(ay & ((56'd1 << ediff[5:0]) - 56'd1));
        end
        ay_sh[0] = ay_sh[0] | sticky;
        sub = x[63] ^ y[63];
        sum = sub ? ({1'b0, ax} - {1'b0, ay_sh}) : ({1'b0, ax} + {1'b0, ay_sh});
        xnan = (x[62:52] == 11'h7ff) && (x[51:0] != 52'd0);
        ynan = (y[62:52] == 11'h7ff) && (y[51:0] != 52'd0);
        xinf = (x[62:52] == 11'h7ff) && (x[51:0] == 52'd0);
        yinf = (y[62:52] == 11'h7ff) && (y[51:0] == 52'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_special     <= xnan || ynan || xinf || yinf;
            r_special_val <= (xnan || ynan || (xinf && yinf && sub)) ? CANON_NAN : x;
            r_sign        <= x[63];
            r_exp         <= ex;
            r_sum         <= sum;
            r_zero_sign   <= x[63] & y[63];
        end
    end

    // Stage two: normalize, round and pack.
    logic [5:0]  lz;
    logic [55:0] norm;
    logic [12:0] e;
    logic [56:0] sh;
    logic [52:0] mant;
    logic        g, s;
    logic [53:0] rnd;
    logic [12:0] ef;

    always_comb begin
        lz = 6'd0;
        norm = 56'd0;
        e = 13'd0;
        sh = 57'd0;
        mant = 53'd0;
        g = 1'b0;
        s = 1'b0;
        rnd = 54'd0;
        ef = 13'd0;
        o_sum = 64'd0;
        if (r_special) begin
            o_sum = r_special_val;
        end else if (r_sum == 57'd0) begin
            o_sum = {r_zero_sign, 63'd0};
        end else if (r_sum[56]) begin
            // Carry out: shift right one, keep sticky.
            norm = {r_sum[56:2], r_sum[1] | r_sum[0]};
            e = {2'b00, r_exp} + 13'd1;
        end else begin
            lz = lzc56(r_sum[55:0]);
            if ({7'd0, lz} >= {2'b00, r_exp} - 13'd1) begin
                // Result becomes subnormal: shift only down to exponent one.
                sh = r_sum << (r_exp - 11'd1);
                e = 13'd0;
            end else begin
                sh = r_sum << lz;
                e = {2'b00, r_exp} - {7'd0, lz};
            end
            norm = sh[55:0];
        end
        if (!r_special && r_sum != 57'd0) begin
            mant = norm[55:3];
            g = norm[2];
            s = norm[1] | norm[0];
            rnd = {1'b0, mant} + {53'd0, g & (s | mant[0])};
            ef = e;
            if (e == 13'd0 && rnd[52]) begin
                ef = 13'd1;
            end
            if (rnd[53]) begin
                rnd = rnd >> 1;
                ef = ef + 13'd1;
            end
            if (ef >= 13'd2047) begin
                o_sum = {r_sign, 11'h7ff, 52'd0};
            end else begin
                o_sum = {r_sign, ef[10:0], rnd[51:0]};
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/nan_boxed_register_vm_execute_top.sv =====
// Top level of the NaN-boxed register VM execute block.
//
// One request channel carries either a constant pool write or a 32-bit
// instruction; one response channel returns one status item per request.
// Registers live in two copies of a synchronous RAM (one per read port), the
// pool in a third. The RAMs are read at the edge that accepts a request, the
// double add runs its first stage on the read data in stage 2, and its second
// stage plus the register write come in stage 3, where the response is
// registered into the output register that drives o_valid.
// Because the next instruction may read the register just written, the block
// holds off a new request while a request that writes a register is in
// stage 1, and the last register write is forwarded to a read that meets it
// at the same edge; otherwise it takes one request per cycle if the response
// side keeps up. The read-add-write loop through the register RAM sets the
// worst-case rate.
// The register file resets to zero with one valid bit per entry; an entry
// not yet written reads as zero, so no clearing pass is needed. The pool has
// no reset. When the receiver stalls, the response holds in the output
// register and a one-entry skid register, the input side stops once both are
// full, and the RAM read addresses of the waiting request are held meanwhile.
`default_nettype none
module nan_boxed_register_vm_execute_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire nbvm_pkg::t_req i_req,
    output logic                o_valid,
    input  wire logic           i_ready,
    output nbvm_pkg::t_rsp      o_rsp
);
    import nbvm_pkg::*;

    localparam int RW = $clog2(NUM_REGS);
    localparam int PW = $clog2(POOL_DEPTH);

    // Pipeline: stage 1 = RAM read, stage 2 = add stage one, stage 3 = write.
    logic        r_v1, r_v2;
    t_ctl        r_c1, r_c2;
    logic [RW-1:0] r_a1, r_a2;
    logic        r_bv1, r_cv1;   // valid bits of read entries, sampled at read
    // Read addresses of stage 1, replayed to the RAMs while the pipeline waits.
    logic [RW-1:0] r_b1, r_rc1;
    logic [PW-1:0] r_rp1;
    logic [NUM_REGS-1:0] r_valid_bits;
    logic        r_wr_pending;   // a register write is in stage 1
    logic [63:0] r_vb2, r_vc2, r_pool2;
    // Most recent register write, which is the current value of that entry.
    logic        r_fwd_v;
    logic [RW-1:0] r_fwd_a;
    logic [63:0] r_fwd_d;

    logic        accept;
    logic        adv;
    logic [RW-1:0] ra_b, ra_c;
    logic [RW-1:0] rda_b, rda_c;
    logic [PW-1:0] rda_p;
    logic [63:0] rd_b, rd_c, rd_p, vb, vc;
    logic        is_exec, writes_reg;
    logic [63:0] sum;

    // Output register plus skid.
    logic        r_ov, r_sv;
    t_rsp        r_o, r_s;
    t_rsp        res;
    logic        res_we;
    logic [63:0] res_wdata;

    // The pipeline advances when the output side can take a result.
    assign adv = !r_sv;
    assign is_exec = i_req.req_type;
    assign writes_reg = is_exec && (i_req.instr_word[7:0] == OP_LOADK ||
                        i_req.instr_word[7:0] == OP_ADD ||
                        i_req.instr_word[7:0] == OP_MOV);
    // Interlock: no new request while a register write is still on its way.
    assign o_ready = adv && !r_wr_pending;
    assign accept  = i_valid && o_ready;

    assign ra_b = i_req.instr_word[16 +: RW];
    assign ra_c = i_req.instr_word[24 +: RW];

    logic [RW-1:0] ra_a;
    assign ra_a = (i_req.instr_word[7:0] == OP_RET) ? i_req.instr_word[8 +: RW] : ra_b;

    // While the pipeline is held, the RAMs keep reading the waiting request.
    assign rda_b = adv ? ra_a : r_b1;
    assign rda_c = adv ? ra_c : r_rc1;
    assign rda_p = adv ? i_req.instr_word[16 +: PW] : r_rp1;

    nbvm_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_regs_b (
        .i_clk(i_clk), .i_we(res_we), .i_waddr(r_a2), .i_wdata(res_wdata),
        .i_raddr(rda_b), .o_rdata(rd_b)
    );
    nbvm_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_regs_c (
        .i_clk(i_clk), .i_we(res_we), .i_waddr(r_a2), .i_wdata(res_wdata),
        .i_raddr(rda_c), .o_rdata(rd_c)
    );
    nbvm_ram #(.WIDTH(64), .DEPTH(POOL_DEPTH)) u_pool (
        .i_clk(i_clk), .i_we(accept && !is_exec), .i_waddr(i_req.pool_index[PW-1:0]),
        .i_wdata(i_req.pool_value), .i_raddr(rda_p), .o_rdata(rd_p)
    );

    // A write landing at the read edge is not seen by the RAM, so take it
    // from the forwarding register instead.
    assign vb = (r_fwd_v && r_fwd_a == r_b1) ? r_fwd_d : (r_bv1 ? rd_b : 64'd0);
    assign vc = (r_fwd_v && r_fwd_a == r_rc1) ? r_fwd_d : (r_cv1 ? rd_c : 64'd0);

    nbvm_fadd u_fadd (
        .i_clk(i_clk), .i_en(adv), .i_a(vb), .i_b(vc), .o_sum(sum)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c1  <= '{is_pool: !is_exec, op: i_req.instr_word[7:0],
                       a: i_req.instr_word[15:8]};
            r_a1  <= i_req.instr_word[8 +: RW];
            r_b1  <= ra_a;
            r_rc1 <= ra_c;
            r_rp1 <= i_req.instr_word[16 +: PW];
            r_bv1 <= r_valid_bits[ra_a];
            r_cv1 <= r_valid_bits[ra_c];
            r_c2  <= r_c1;
            r_a2  <= r_a1;
            r_vb2 <= vb;
            r_vc2 <= vc;
            r_pool2 <= rd_p;
        end
    end

    // Stage 3: resolve the result and register write.
    always_comb begin
        res = '{status: ST_DONE, return_value: 64'd0, return_is_number: 1'b0};
        res_we = 1'b0;
        res_wdata = 64'd0;
        if (r_c2.is_pool) begin
            res.status = ST_POOL;
        end else begin
            unique case (r_c2.op)
                OP_HALT: res.status = ST_HALT;
                OP_LOADK: begin
                    res_we = 1'b1;
                    res_wdata = r_pool2;
                end
                OP_ADD: begin
                    if (is_plain_num(r_vb2) && is_plain_num(r_vc2)) begin
                        res_we = 1'b1;
                        res_wdata = sum;
                    end else begin
                        res.status = ST_TYPE_ERR;
                    end
                end
                OP_RET: begin
                    res.status = ST_RETURN;
                    res.return_value = r_vb2;
                    res.return_is_number = is_plain_num(r_vb2);
                end
                OP_MOV: begin
                    res_we = 1'b1;
                    res_wdata = r_vb2;
                end
                default: res.status = ST_BAD_OP;
            endcase
        end
        res_we = res_we && r_v2 && adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_wr_pending <= 1'b0;
            r_valid_bits <= '0;
            r_fwd_v <= 1'b0;
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (adv) begin
                r_v1 <= accept;
                r_v2 <= r_v1;
                r_wr_pending <= accept && writes_reg;
            end
            if (res_we) begin
                r_valid_bits[r_a2] <= 1'b1;
                r_fwd_v <= 1'b1;
                r_fwd_a <= r_a2;
                r_fwd_d <= res_wdata;
            end
            // Output register and skid.
            if (r_ov && !i_ready && adv && r_v2) begin
                r_sv <= 1'b1;
                r_s  <= res;
            end else if (i_ready && r_sv) begin
                r_sv <= 1'b0;
                r_o  <= r_s;
            end else if (!r_ov || i_ready) begin
                r_ov <= adv && r_v2;
                r_o  <= res;
            end
            if (i_ready && r_sv) begin
                r_ov <= 1'b1;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_rsp   = r_o;
endmodule
`default_nettype wire

// ===== rtl/core/nbvm_checker.sv =====
// Port-level checker for the VM execute block, bound to the top level.
`default_nettype none
module nbvm_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_valid,
    input wire logic           i_ready,
    input wire nbvm_pkg::t_rsp o_rsp
);
    import nbvm_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("response changed while stalled");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.status <= ST_POOL)
        else $error("status out of range");
    a_retzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != ST_RETURN |->
        o_rsp.return_value == 64'd0 && !o_rsp.return_is_number)
        else $error("return fields set on non-return");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind nan_boxed_register_vm_execute_top nbvm_checker u_nbvm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
);
`default_nettype wire

// ===== bench/tb_nan_boxed_register_vm_execute_top.sv =====
// Self-checking testbench for the NaN-boxed register VM execute block.
`default_nettype none
module tb_nan_boxed_register_vm_execute_top;
    import nbvm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_req  i_req;
    logic  o_valid;
    logic  i_ready;
    t_rsp  o_rsp;

    nan_boxed_register_vm_execute_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_rsp  (o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the machine state, updated as each request is accepted.
    logic [63:0] vm_regs [256];
    logic [63:0] vm_pool [256];
    bit          pool_written [256];
    t_rsp        pending_rsps [$];
    int          n_errors;
    longint      cycle_count = 0;

    // Directed rows: the request and, where obvious, the response typed in.
    typedef struct {
        t_req  req;
        bit    has_rsp;
        t_rsp  rsp;
    } t_row;

    function automatic logic is_num(input logic [63:0] v);
        return (v & 64'h7ffc000000000000) != 64'h7ffc000000000000;
    endfunction

    // IEEE double add, round to nearest even, any NaN collapsed to the quiet form.
    function automatic logic [63:0] fadd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] s;
        s = $realtobits($bitstoreal(x) + $bitstoreal(y));
        if (s[62:52] == 11'h7ff && s[51:0] != 0) s = CANON_NAN;
        return s;
    endfunction

    // Runs one request through the shadow machine and returns its response.
    function automatic t_rsp vm_execute(input t_req r);
        t_rsp        o;
        logic [7:0]  op, a, b, c;
        logic [63:0] vb, vc;
        op = r.instr_word[7:0];
        a  = r.instr_word[15:8];
        b  = r.instr_word[23:16];
        c  = r.instr_word[31:24];
        o  = '0;
        if (!r.req_type) begin
            vm_pool[r.pool_index] = r.pool_value;
            pool_written[r.pool_index] = 1'b1;
            o.status = ST_POOL;
        end else begin
            case (op)
                OP_HALT:  o.status = ST_HALT;
                OP_LOADK: begin
                    vm_regs[a] = vm_pool[b];
                    o.status = ST_DONE;
                end
                OP_ADD: begin
                    vb = vm_regs[b];
                    vc = vm_regs[c];
                    if (is_num(vb) && is_num(vc)) begin
                        vm_regs[a] = fadd64(vb, vc);
                        o.status = ST_DONE;
                    end else begin
                        o.status = ST_TYPE_ERR;
                    end
                end
                OP_RET: begin
                    o.status = ST_RETURN;
                    o.return_value = vm_regs[a];
                    o.return_is_number = is_num(vm_regs[a]);
                end
                OP_MOV: begin
                    vm_regs[a] = vm_regs[b];
                    o.status = ST_DONE;
                end
                default: o.status = ST_BAD_OP;
            endcase
        end
        return o;
    endfunction

    function automatic t_req instr(input logic [7:0] op, input logic [7:0] a,
                                   input logic [7:0] b, input logic [7:0] c);
        t_req r;
        r = '0;
        r.req_type = 1'b1;
        r.pool_value = {$urandom, $urandom};
        r.pool_index = 8'($urandom);
        r.instr_word = {c, b, a, op};
        return r;
    endfunction

    function automatic t_req pool_wr(input logic [7:0] idx, input logic [63:0] v);
        t_req r;
        r = '0;
        r.pool_index = idx;
        r.pool_value = v;
        r.instr_word = $urandom;
        return r;
    endfunction

    // A double that is a number most of the time, boxed or special otherwise.
    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom} | BOX_MASK;
            1: return 64'h7ff0000000000000 | ({63'b0, 1'($urandom)} << 63);
            2: return {$urandom, $urandom};
            3: return 64'h7fefffffffffffff;
            4: return {1'($urandom), 11'd0, 20'($urandom), 32'($urandom)};
            default: return $realtobits(($urandom_range(0, 2000) - 1000.0) /
                                        real'($urandom_range(1, 64)));
        endcase
    endfunction

    // Drives one request, honoring a random gap and the handshake.
    task automatic send(input t_req r);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_rsps.push_back(vm_execute(r));
    endtask

    // Sends a directed row; a typed-in response must agree with the predictor.
    task automatic send_row(input t_row row);
        t_rsp p;
        send(row.req);
        p = pending_rsps[$];
        if (row.has_rsp && p !== row.rsp) begin
            $error("directed row: expected %h, predictor gives %h", row.rsp, p);
            n_errors++;
        end
    endtask

    // Receiver: random stall per response, checking against the oldest entry.
    initial begin
        t_rsp exp_rsp;
        int   stall;
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 2) == 0) stall = 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (pending_rsps.size() == 0) begin
                $error("response with nothing pending: %h", o_rsp);
                n_errors++;
            end else begin
                exp_rsp = pending_rsps.pop_front();
                if (o_rsp.status !== exp_rsp.status) begin
                    $error("status: expected %0d, actual %0d",
                           exp_rsp.status, o_rsp.status);
                    n_errors++;
                end
                if (o_rsp.return_value !== exp_rsp.return_value) begin
                    $error("return_value: expected %h, actual %h",
                           exp_rsp.return_value, o_rsp.return_value);
                    n_errors++;
                end
                if (o_rsp.return_is_number !== exp_rsp.return_is_number) begin
                    $error("return_is_number: expected %b, actual %b",
                           exp_rsp.return_is_number, o_rsp.return_is_number);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_row        rows [$];
        t_row        row;
        t_rsp        rz;
        logic [7:0]  ra, rb, rc, op;
        logic [7:0]  written [$];
        int          kind;
        n_errors    = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req       = '0;
        foreach (vm_regs[k]) begin
            vm_regs[k] = '0;
            vm_pool[k] = '0;
            pool_written[k] = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset values, every opcode, extremes and error cases.
        rz = '0;
        row.has_rsp = 1'b1;
        // A register still at reset holds zero, which is a plain number.
        rz.status = ST_RETURN;
        rz.return_is_number = 1'b1;
        row.req = instr(OP_RET, 8'd0, 8'd0, 8'd0); row.rsp = rz; rows.push_back(row);
        row.req = instr(OP_RET, 8'hff, 8'hff, 8'hff); rows.push_back(row);
        rz.return_is_number = 1'b0;
        rz.status = ST_POOL;
        row.req = pool_wr(8'd0, 64'd0); row.rsp = rz; rows.push_back(row);
        row.req = pool_wr(8'hff, 64'hffffffffffffffff); rows.push_back(row);
        row.req = pool_wr(8'h01, 64'h3ff0000000000000); rows.push_back(row);
        row.req = pool_wr(8'h02, BOX_MASK | 64'h1234); rows.push_back(row);
        row.req = pool_wr(8'h03, 64'h7ff0000000000000); rows.push_back(row);
        row.req = pool_wr(8'h04, 64'hfff0000000000000); rows.push_back(row);
        row.req = pool_wr(8'h05, CANON_NAN); rows.push_back(row);
        rz.status = ST_HALT;
        row.req = instr(OP_HALT, 8'hff, 8'hff, 8'hff); row.rsp = rz; rows.push_back(row);
        rz.status = ST_BAD_OP;
        row.req = instr(8'd5, 8'd0, 8'd0, 8'd0); row.rsp = rz; rows.push_back(row);
        row.req = instr(8'hff, 8'd1, 8'd1, 8'd1); rows.push_back(row);
        row.has_rsp = 1'b0;
        row.req = instr(OP_LOADK, 8'hff, 8'hff, 8'd0); rows.push_back(row);
        row.req = instr(OP_LOADK, 8'd1, 8'd1, 8'hff); rows.push_back(row);
        row.req = instr(OP_LOADK, 8'd2, 8'd2, 8'd0); rows.push_back(row);
        row.req = instr(OP_LOADK, 8'd3, 8'd3, 8'd0); rows.push_back(row);
        row.req = instr(OP_LOADK, 8'd4, 8'd4, 8'd0); rows.push_back(row);
        row.req = instr(OP_ADD, 8'd6, 8'd1, 8'd1); rows.push_back(row);
        row.req = instr(OP_ADD, 8'd7, 8'd3, 8'd4); rows.push_back(row); // inf - inf
        row.req = instr(OP_ADD, 8'd8, 8'd1, 8'd2); rows.push_back(row); // boxed operand
        row.req = instr(OP_MOV, 8'd9, 8'd2, 8'hff); rows.push_back(row);
        row.req = instr(OP_RET, 8'd7, 8'd0, 8'd0); rows.push_back(row);
        row.req = instr(OP_RET, 8'd9, 8'd0, 8'd0); rows.push_back(row);
        row.req = instr(OP_RET, 8'hff, 8'd0, 8'd0); rows.push_back(row);
        foreach (rows[k]) send_row(rows[k]);
        for (int k = 0; k < 6; k++) written.push_back(8'(k));
        written.push_back(8'hff);

        // Hold off until the block has drained everything.
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_rsps.size() != 0);

        // Random part: mostly valid instructions over a small working set of
        // registers so that values flow between ADD, MOV and RETURN.
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 99);
            ra = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            rb = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            rc = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            if (kind < 15) begin
                rb = 8'($urandom);
                if (!pool_written[rb]) written.push_back(rb);
                send(pool_wr(rb, rand_value()));
            end else if (kind < 30) begin
                rb = written[$urandom_range(0, written.size() - 1)];
                send(instr(OP_LOADK, ra, rb, 8'($urandom)));
            end else if (kind < 60) begin
                send(instr(OP_ADD, ra, rb, rc));
            end else if (kind < 75) begin
                send(instr(OP_MOV, ra, rb, 8'($urandom)));
            end else if (kind < 93) begin
                send(instr(OP_RET, ra, 8'($urandom), 8'($urandom)));
            end else if (kind < 96) begin
                send(instr(OP_HALT, ra, rb, rc));
            end else begin
                op = 8'($urandom_range(5, 255));
                send(instr(op, ra, rb, rc));
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_rsps.size() != 0);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/nbvm_pkg.sv
rtl/core/nbvm_ram.sv
rtl/core/nbvm_fadd.sv
rtl/core/nan_boxed_register_vm_execute_top.sv
rtl/core/nbvm_checker.sv
bench/tb_nan_boxed_register_vm_execute_top.sv
